// ===== hw/rtl/streaming_pearson_correlation_defines.svh =====
// Assertion macros shared by the streaming correlation RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef STREAMING_PEARSON_CORRELATION_DEFINES_SVH
`define STREAMING_PEARSON_CORRELATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define SPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SPC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SPC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/spc_pkg.sv =====
// Types, codes and saturating helpers for the streaming correlation block.
// Used by every module of the block; depends on nothing.
package spc_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int ACC_W = 64;
	localparam int RHO_W = 32;
	localparam logic [RHO_W-1:0] RHO_ONE = 32'h4000_0000;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [1:0] TERM_UU = 2'd0;
	localparam logic [1:0] TERM_VV = 2'd1;
	localparam logic [1:0] TERM_UV = 2'd2;
	localparam logic [1:0] TERM_PROD = 2'd3;
	localparam logic [1:0] MEAN_U = 2'd0;
	localparam logic [1:0] MEAN_V = 2'd1;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_u;
		logic signed [SAMPLE_WIDTH-1:0] sample_v;
		logic last;
	} spc_in_t;

	typedef struct packed {
		logic signed [RHO_W-1:0] correlation;
		logic undefined;
	} spc_out_t;

	typedef struct packed {
		logic load;
		logic seed;
		logic diff;
		logic mul_start;
		logic div_start;
		logic div_mean;
		logic acc_term;
		logic mean_upd;
		logic count_inc;
		logic root_start;
		logic emit;
		logic [1:0] term;
	} spc_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic zero_sum;
		logic mul_done;
		logic div_done;
		logic root_done;
		logic rho_done;
	} spc_stat_t;

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] a);
		return a[ACC_W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic signed [ACC_W-1:0] from_mag(input logic neg,
			input logic [ACC_W-1:0] m);
		if (neg) begin
			return m[ACC_W-1] ? ACC_MIN : (~m + 1'b1);
		end
		return m[ACC_W-1] ? ACC_MAX : m;
	endfunction

endpackage

// ===== hw/rtl/streaming_pearson_correlation.sv =====
// Channel  | valid        | stall        | payload
// pair     | pair_valid   | pair_stall   | pair   (sample_u, sample_v, last)
// result   | result_valid | result_stall | result (correlation, undefined)
//
// A seeding pair is loaded and seeds the means and the count. A later pair makes five
// passes through the one shared radix-2 divider, plus three products.
// A last pair then adds one product, a 64-step root and a 94-step ratio, unless a sum is zero.
// Reset clears all running sums; a result waits in its register while the next pair
// is taken, and a second result waits in the controller until that register empties.
// Top level of the streaming correlation block; depends on spc_pkg, spc_ctl, spc_dp.
module streaming_pearson_correlation #(
	parameter int FRAC_BITS = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pair_valid,
	output logic pair_stall,
	input  spc_pkg::spc_in_t pair,
	output logic result_valid,
	input  logic result_stall,
	output spc_pkg::spc_out_t result
);
	import spc_pkg::*;

	spc_cmd_t cmd;
	spc_stat_t stat;

	spc_ctl u_ctl (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall),
		.result_valid(result_valid), .result_stall(result_stall),
		.stat(stat), .cmd(cmd)
	);

	spc_dp #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .pair(pair), .cmd(cmd),
		.stat(stat), .result(result)
	);

endmodule

// ===== hw/rtl/spc_mul.sv =====
// Iterative 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on spc_pkg for widths.
module spc_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [spc_pkg::ACC_W-1:0] a,
	input  logic [spc_pkg::ACC_W-1:0] b,
	output logic done,
	output logic [2*spc_pkg::ACC_W-1:0] prod
);
	import spc_pkg::*;

	localparam int HW = ACC_W / 2;

	logic [ACC_W-1:0] a_q, b_q;
	logic [1:0] step_q;
	logic busy_q, pp_vld_s1, pp_last_s1, done_q;
	logic [ACC_W-1:0] pp_s1;
	logic [1:0] sh_s1;
	logic [2*ACC_W-1:0] acc_q;
	logic [HW-1:0] opa, opb;

	assign opa = step_q[1] ? a_q[ACC_W-1:HW] : a_q[HW-1:0];
	assign opb = step_q[0] ? b_q[ACC_W-1:HW] : b_q[HW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			pp_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pp_vld_s1 <= busy_q;
			done_q <= pp_vld_s1 && pp_last_s1;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= ACC_W'(opa * opb);
		sh_s1 <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
		pp_last_s1 <= (step_q == 2'd3);
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + ({{ACC_W{1'b0}}, pp_s1} << {sh_s1, 5'd0});
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== hw/rtl/spc_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on spc_pkg for widths.
module spc_div #(
	parameter int DW = 33
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [spc_pkg::ACC_W-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic done,
	output logic [spc_pkg::ACC_W-1:0] quotient
);
	import spc_pkg::*;

	logic [ACC_W-1:0] quo_q;
	logic [DW-1:0] rem_q, dsr_q;
	logic [6:0] cnt_q;
	logic done_q;
	logic [DW:0] rr, diff;
	logic ge;

	assign rr = {rem_q, quo_q[ACC_W-1]};
	assign diff = rr - {1'b0, dsr_q};
	assign ge = (rr >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (start) begin
				cnt_q <= 7'(ACC_W);
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			rem_q <= ge ? diff[DW-1:0] : rr[DW-1:0];
			quo_q <= {quo_q[ACC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/spc_dp.sv =====
// Datapath: running means and sums, shared multiplier and divider,
// square root and final ratio. Depends on spc_pkg, spc_mul and spc_div.
module spc_dp #(
	parameter int FRAC_BITS = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  spc_pkg::spc_in_t pair,
	input  spc_pkg::spc_cmd_t cmd,
	output spc_pkg::spc_stat_t stat,
	output spc_pkg::spc_out_t result
);
	import spc_pkg::*;

	localparam int SH = 32 - FRAC_BITS;
	localparam int NUM_W = ACC_W + 30;

	logic signed [ACC_W-1:0] u_q, v_q, mean_u_q, mean_v_q, du_q, dv_q;
	logic signed [ACC_W-1:0] dsu_q, dsv_q, cds_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic first_q, last_q;
	logic signed [ACC_W-1:0] u_cv, v_cv;

	logic [ACC_W-1:0] mul_a, mul_b, wsat, div_dvd, quo, wt;
	logic [2*ACC_W-1:0] prod;
	logic mul_done, div_done, neg_term;
	logic signed [ACC_W-1:0] term_val, mean_val;

	logic [2*ACC_W-1:0] rad_q;
	logic [ACC_W-1:0] root_q, s_q, r_q;
	logic [ACC_W+2:0] rrem_q, rem_sh, trial;
	logic [NUM_W-1:0] num_q;
	logic [RHO_W-1:0] q_q, qn, qc;
	logic [6:0] it_q;
	logic root_busy_q, rho_busy_q, root_done_q, rho_done_q, root_ge, rho_ge;
	logic [ACC_W:0] rr, rdiff;
	spc_out_t res_q;

	assign u_cv = ACC_W'(signed'(pair.sample_u)) <<< SH;
	assign v_cv = ACC_W'(signed'(pair.sample_v)) <<< SH;

	always_comb begin
		case (cmd.term)
			TERM_UU: begin
				mul_a = mag(du_q);
				mul_b = mag(du_q);
			end
			TERM_VV: begin
				mul_a = mag(dv_q);
				mul_b = mag(dv_q);
			end
			TERM_UV: begin
				mul_a = mag(du_q);
				mul_b = mag(dv_q);
			end
			default: begin
				mul_a = dsu_q;
				mul_b = dsv_q;
			end
		endcase
	end

	spc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
	);

	// Product truncated to Q32.32, then limited to 2^63 before weighting.
	always_comb begin
		if (prod[2*ACC_W-1:96] != '0 || prod[95:32] > {1'b1, 63'd0}) begin
			wsat = {1'b1, 63'd0};
		end else begin
			wsat = prod[95:32];
		end
	end

	assign div_dvd = !cmd.div_mean ? wsat :
		(cmd.term == MEAN_U) ? mag(du_q) : mag(dv_q);

	spc_div #(.DW(COUNT_WIDTH + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_dvd), .divisor({1'b0, cnt_q} + (COUNT_WIDTH + 1)'(1)),
		.done(div_done), .quotient(quo)
	);

	assign neg_term = (cmd.term == TERM_UV) && (du_q[ACC_W-1] ^ dv_q[ACC_W-1]);
	assign wt = wsat - quo;
	assign term_val = from_mag(neg_term && (wt != '0), wt);
	assign mean_val = from_mag((cmd.term == MEAN_U) ? du_q[ACC_W-1] : dv_q[ACC_W-1], quo);

	// Square root: two radicand bits per cycle.
	assign rem_sh = {rrem_q[ACC_W:0], rad_q[2*ACC_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign root_ge = (rem_sh >= trial);

	// Ratio: long division with the quotient held just above one once it passes.
	assign rr = {r_q, num_q[NUM_W-1]};
	assign rdiff = rr - {1'b0, s_q};
	assign rho_ge = (rr >= {1'b0, s_q});
	assign qn = {q_q[RHO_W-2:0], rho_ge};
	assign qc = (q_q > RHO_ONE) ? RHO_ONE : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			mean_u_q <= '0;
			mean_v_q <= '0;
			dsu_q <= '0;
			dsv_q <= '0;
			cds_q <= '0;
			cnt_q <= '0;
			it_q <= '0;
			root_busy_q <= 1'b0;
			rho_busy_q <= 1'b0;
			root_done_q <= 1'b0;
			rho_done_q <= 1'b0;
		end else begin
			root_done_q <= root_busy_q && (it_q == 7'd1);
			rho_done_q <= rho_busy_q && (it_q == 7'd1);
			if (cmd.root_start) begin
				it_q <= 7'(ACC_W);
				root_busy_q <= 1'b1;
			end else if (root_done_q) begin
				it_q <= 7'(NUM_W);
				root_busy_q <= 1'b0;
				rho_busy_q <= 1'b1;
			end else if (it_q != 7'd0) begin
				it_q <= it_q - 7'd1;
			end else begin
				rho_busy_q <= 1'b0;
			end
			if (cmd.seed) begin
				mean_u_q <= u_q;
				mean_v_q <= v_q;
				cnt_q <= COUNT_WIDTH'(1);
				first_q <= 1'b0;
			end
			if (cmd.acc_term) begin
				case (cmd.term)
					TERM_UU: dsu_q <= sat_add(dsu_q, term_val);
					TERM_VV: dsv_q <= sat_add(dsv_q, term_val);
					TERM_UV: cds_q <= sat_add(cds_q, term_val);
					default: cds_q <= cds_q;
				endcase
			end
			if (cmd.mean_upd) begin
				if (cmd.term == MEAN_U) begin
					mean_u_q <= sat_add(mean_u_q, mean_val);
				end else begin
					mean_v_q <= sat_add(mean_v_q, mean_val);
				end
			end
			if (cmd.count_inc && cnt_q != {COUNT_WIDTH{1'b1}}) begin
				cnt_q <= cnt_q + COUNT_WIDTH'(1);
			end
			if (cmd.emit) begin
				first_q <= 1'b1;
				mean_u_q <= '0;
				mean_v_q <= '0;
				dsu_q <= '0;
				dsv_q <= '0;
				cds_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q <= u_cv;
			v_q <= v_cv;
			last_q <= pair.last;
		end
		if (cmd.diff) begin
			du_q <= sat_sub(u_q, mean_u_q);
			dv_q <= sat_sub(v_q, mean_v_q);
		end
		if (cmd.root_start) begin
			rad_q <= prod;
			root_q <= '0;
			rrem_q <= '0;
		end else if (root_busy_q && it_q != 7'd0) begin
			rrem_q <= root_ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ACC_W-2:0], root_ge};
			rad_q <= {rad_q[2*ACC_W-3:0], 2'b00};
		end
		if (root_done_q) begin
			s_q <= (root_q == '0) ? ACC_W'(1) : root_q;
			num_q <= {mag(cds_q), 30'd0};
			r_q <= '0;
			q_q <= '0;
		end else if (rho_busy_q && it_q != 7'd0) begin
			r_q <= rho_ge ? rdiff[ACC_W-1:0] : rr[ACC_W-1:0];
			q_q <= (qn > RHO_ONE) ? (RHO_ONE + RHO_W'(1)) : qn;
			num_q <= {num_q[NUM_W-2:0], 1'b0};
		end
		if (cmd.emit) begin
			res_q.undefined <= stat.zero_sum;
			if (stat.zero_sum) begin
				res_q.correlation <= '0;
			end else begin
				res_q.correlation <= cds_q[ACC_W-1] ? (~qc + 1'b1) : qc;
			end
		end
	end

	assign stat.first = first_q;
	assign stat.last = last_q;
	assign stat.zero_sum = dsu_q[ACC_W-1] || (dsu_q == '0) || dsv_q[ACC_W-1] || (dsv_q == '0);
	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.root_done = root_done_q;
	assign stat.rho_done = rho_done_q;
	assign result = res_q;

endmodule

// ===== hw/rtl/spc_ctl.sv =====
// Controller: sequences the datapath per pair and owns the result handshake.
// Depends on spc_pkg and the assertion macro header.
`include "streaming_pearson_correlation_defines.svh"
module spc_ctl (
	input  logic clk,
	input  logic arst_n,
	input  logic pair_valid,
	output logic pair_stall,
	output logic result_valid,
	input  logic result_stall,
	input  spc_pkg::spc_stat_t stat,
	output spc_pkg::spc_cmd_t cmd
);
	import spc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SEED = 4'd1;
	localparam logic [3:0] ST_DIFF = 4'd2;
	localparam logic [3:0] ST_MUL = 4'd3;
	localparam logic [3:0] ST_MULW = 4'd4;
	localparam logic [3:0] ST_DIVW = 4'd5;
	localparam logic [3:0] ST_ACC = 4'd6;
	localparam logic [3:0] ST_MDIV = 4'd7;
	localparam logic [3:0] ST_MDIVW = 4'd8;
	localparam logic [3:0] ST_MACC = 4'd9;
	localparam logic [3:0] ST_COUNT = 4'd10;
	localparam logic [3:0] ST_FINISH = 4'd11;
	localparam logic [3:0] ST_ROOTW = 4'd12;
	localparam logic [3:0] ST_RHOW = 4'd13;
	localparam logic [3:0] ST_EMIT = 4'd14;

	logic [3:0] state_q, state_d;
	logic [1:0] term_q, term_d;
	logic res_valid_q;

	always_comb begin
		cmd = '0;
		cmd.term = term_q;
		state_d = state_q;
		term_d = term_q;
		case (state_q)
			ST_IDLE: begin
				if (pair_valid) begin
					cmd.load = 1'b1;
					state_d = stat.first ? ST_SEED : ST_DIFF;
				end
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d = stat.last ? ST_FINISH : ST_IDLE;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				term_d = TERM_UU;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_d = ST_MULW;
			end
			ST_MULW: begin
				if (stat.mul_done) begin
					if (term_q == TERM_PROD) begin
						cmd.root_start = 1'b1;
						state_d = ST_ROOTW;
					end else begin
						cmd.div_start = 1'b1;
						state_d = ST_DIVW;
					end
				end
			end
			ST_DIVW: begin
				if (stat.div_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_term = 1'b1;
				if (term_q == TERM_UV) begin
					term_d = MEAN_U;
					state_d = ST_MDIV;
				end else begin
					term_d = term_q + 2'd1;
					state_d = ST_MUL;
				end
			end
			ST_MDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_mean = 1'b1;
				state_d = ST_MDIVW;
			end
			ST_MDIVW: begin
				if (stat.div_done) begin
					state_d = ST_MACC;
				end
			end
			ST_MACC: begin
				cmd.mean_upd = 1'b1;
				if (term_q == MEAN_U) begin
					term_d = MEAN_V;
					state_d = ST_MDIV;
				end else begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count_inc = 1'b1;
				state_d = stat.last ? ST_FINISH : ST_IDLE;
			end
			ST_FINISH: begin
				if (stat.zero_sum) begin
					state_d = ST_EMIT;
				end else begin
					term_d = TERM_PROD;
					state_d = ST_MUL;
				end
			end
			ST_ROOTW: begin
				if (stat.root_done) begin
					state_d = ST_RHOW;
				end
			end
			ST_RHOW: begin
				if (stat.rho_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!res_valid_q) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q <= TERM_UU;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			term_q <= term_d;
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign pair_stall = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;

	`SPC_ASSERT_IMP(a_emit_slot_free, clk, arst_n, cmd.emit, !res_valid_q)
	`SPC_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, pair_valid && !pair_stall, state_q != ST_IDLE)
	`SPC_ASSERT_IMP(a_valid_from_emit, clk, arst_n, $rose(res_valid_q), $past(cmd.emit))

endmodule
